[rtl/swc_pkg.sv]
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, codes and constants of the shifted address write cache: the
// access and result codes, the register map and the controller interface.
// ----------------------------------------------------------------------------
package swc_pkg;

	localparam int ADDR_BITS      = 10;
	localparam int DATA_PORT_BITS = 16;
	localparam int BACK_BITS      = 12;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 10;
	localparam int MODE_BITS      = 2;
	localparam int CHUNK_BITS     = 2;
	localparam int ADDR_MAX       = (1 << ADDR_BITS) - 1;

	localparam int SEGMENT_WORDS_DEF  = 1024;
	localparam int BUFFER_ENTRIES_DEF = 16;
	localparam int DATA_BITS_DEF      = 16;

	localparam logic [MODE_BITS-1:0] MODE_PASS = 2'd0;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_BUF_DATA = 2'd0,
		KIND_READ_REQ = 2'd1,
		KIND_WRITE    = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MODE  = 2'd0,
		REG_SHIFT = 2'd1,
		REG_CHUNK = 2'd2
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic red_step;
		logic phys_calc;
		logic match;
		logic wb_start;
		logic wb_step;
		logic final_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic red_skip;
		logic red_done;
		logic need_wb;
		logic wb_last;
		logic out_free;
	} sts_t;

	// restoring steps needed to bring an address below the segment size
	function automatic int red_steps(input int seg);
		int n;
		n = 0;
		for (int k = 0; k < 17; k++) begin
			if ((longint'(seg) << k) <= longint'(ADDR_MAX)) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

endpackage

[rtl/swc_ctrl.sv]
// ----------------------------------------------------------------------------
// swc_ctrl
// Sequencer of the write cache: walks each access through reduction, address
// rotation, buffer lookup, optional write-back and the final result.
// ----------------------------------------------------------------------------
module swc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output swc_pkg::cmd_t cmd,
	input  swc_pkg::sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_REDUCE   = 7'b0000010,
		ST_PHYS     = 7'b0000100,
		ST_MATCH    = 7'b0001000,
		ST_DISPATCH = 7'b0010000,
		ST_WB       = 7'b0100000,
		ST_FINAL    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.red_skip ? ST_PHYS : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.red_step = 1'b1;
				if (sts.red_done) begin
					state_d = ST_PHYS;
				end
			end
			ST_PHYS: begin
				cmd.phys_calc = 1'b1;
				state_d       = ST_MATCH;
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (sts.need_wb) begin
					cmd.wb_start = 1'b1;
					state_d      = ST_WB;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_WB: begin
				if (sts.out_free) begin
					cmd.wb_step = 1'b1;
					if (sts.wb_last) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.final_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/swc_datapath.sv]
// ----------------------------------------------------------------------------
// swc_datapath
// Configuration registers, address reduction and rotation, the fully
// associative write buffer, the wear counter and the result register.
// ----------------------------------------------------------------------------
module swc_datapath #(
	parameter int SEGMENT_WORDS  = swc_pkg::SEGMENT_WORDS_DEF,
	parameter int BUFFER_ENTRIES = swc_pkg::BUFFER_ENTRIES_DEF,
	parameter int DATA_BITS      = swc_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swc_pkg::cmd_t                      cmd,
	output swc_pkg::sts_t                      sts,
	input  logic                               cfg_we,
	input  logic [swc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [swc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [1:0]                         action,
	input  logic [swc_pkg::ADDR_BITS-1:0]      logical_address,
	input  logic [swc_pkg::DATA_PORT_BITS-1:0] write_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [1:0]                         kind,
	output logic [swc_pkg::BACK_BITS-1:0]      backing_address,
	output logic [swc_pkg::DATA_PORT_BITS-1:0] data_word,
	output logic                               last,
	output logic [31:0]                        wear_count
);

	localparam int AB  = swc_pkg::ADDR_BITS;
	localparam int BB  = swc_pkg::BACK_BITS;
	localparam int PB  = swc_pkg::DATA_PORT_BITS;
	localparam int AW  = $clog2(SEGMENT_WORDS);
	localparam int DW  = (DATA_BITS < PB) ? DATA_BITS : PB;
	localparam int RW  = ((AW > AB) ? AW : AB) + 2;
	localparam int IW  = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
	localparam int FW  = $clog2(BUFFER_ENTRIES + 1);
	localparam int MW  = AW + DW;
	localparam int RED_STEPS = swc_pkg::red_steps(SEGMENT_WORDS);
	localparam int RED_TOP   = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
	localparam int RCW       = (RED_TOP > 0) ? $clog2(RED_TOP + 1) : 1;

	// configuration
	logic [swc_pkg::MODE_BITS-1:0]  mode_q;
	logic [AB-1:0]                  shift_q;
	logic [swc_pkg::CHUNK_BITS-1:0] chunk_q;

	// current access
	swc_pkg::action_t action_q;
	logic [AB-1:0]    virt_q;
	logic [AB-1:0]    rshift_q;
	logic [DW-1:0]    data_q;
	logic [RCW-1:0]   red_cnt_q;
	logic [AW-1:0]    phys_q;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;

	// buffer
	logic [AW-1:0]    cam_q [BUFFER_ENTRIES];
	logic [MW-1:0]    mem_q [BUFFER_ENTRIES];
	logic [MW-1:0]    rd_q;
	logic [FW-1:0]    fill_q;
	logic [IW-1:0]    wb_idx_q;

	logic [31:0]      wear_q;

	// result register
	logic             out_valid_q;
	swc_pkg::kind_t   kind_q;
	logic [BB-1:0]    back_q;
	logic [PB-1:0]    dword_q;
	logic             last_q;
	logic [31:0]      wear_out_q;

	logic                      pass;
	logic [RW-1:0]             seg_k;
	logic [RW-1:0]             phys_sum;
	logic [RW-1:0]             phys_red;
	logic [BUFFER_ENTRIES-1:0] match;
	logic [IW-1:0]             match_idx;
	logic                      rd_en;
	logic [IW-1:0]             rd_addr;
	logic                      wb_last;
	logic                      buf_write;
	logic                      buf_append;
	logic [IW-1:0]             wr_idx;
	logic                      final_wear;
	logic                      wear_bump;
	logic [31:0]               wear_inc;
	logic [BB-1:0]             chunk_base;
	logic [BB-1:0]             virt_back;
	logic [BB-1:0]             phys_back;
	swc_pkg::kind_t            fin_kind;
	logic [BB-1:0]             fin_back;
	logic [PB-1:0]             fin_data;
	logic                      out_free;

	assign pass       = (mode_q == swc_pkg::MODE_PASS);
	assign chunk_base = BB'(chunk_q) * BB'(SEGMENT_WORDS);
	assign virt_back  = BB'(virt_q) + chunk_base;
	assign phys_back  = BB'(phys_q) + chunk_base;
	assign out_free   = !out_valid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			shift_q <= '0;
			chunk_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				swc_pkg::REG_MODE:  mode_q  <= cfg_data[swc_pkg::MODE_BITS-1:0];
				swc_pkg::REG_SHIFT: shift_q <= cfg_data[AB-1:0];
				swc_pkg::REG_CHUNK: chunk_q <= cfg_data[swc_pkg::CHUNK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// modulo reduction, one restoring step per cycle from the top multiple
	assign seg_k = RW'(SEGMENT_WORDS) << red_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q  <= swc_pkg::action_t'(action);
			virt_q    <= logical_address;
			rshift_q  <= shift_q;
			data_q    <= write_data[DW-1:0];
			red_cnt_q <= RCW'(RED_TOP);
		end else if (cmd.red_step) begin
			if (RW'(virt_q) >= seg_k) begin
				virt_q <= virt_q - seg_k[AB-1:0];
			end
			if (RW'(rshift_q) >= seg_k) begin
				rshift_q <= rshift_q - seg_k[AB-1:0];
			end
			red_cnt_q <= red_cnt_q - RCW'(1);
		end
	end

	// rotated address: virt - shift modulo segment size
	assign phys_sum = RW'(virt_q) + RW'(SEGMENT_WORDS) - RW'(rshift_q);
	assign phys_red = (phys_sum >= RW'(SEGMENT_WORDS)) ? phys_sum - RW'(SEGMENT_WORDS)
		: phys_sum;

	always_ff @(posedge clk) begin
		if (cmd.phys_calc) begin
			phys_q <= phys_red[AW-1:0];
		end
	end

	// tag compare, addresses among valid entries are unique
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < BUFFER_ENTRIES; i++) begin
			match[i] = (FW'(i) < fill_q) && (cam_q[i] == phys_q);
			if (match[i]) begin
				match_idx = match_idx | IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_q     <= |match;
			hit_idx_q <= match_idx;
		end
	end

	assign wb_last = (FW'(wb_idx_q) + FW'(1) == fill_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = wb_idx_q;
		if (cmd.match) begin
			rd_en   = 1'b1;
			rd_addr = match_idx;
		end else if (cmd.wb_start) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if (cmd.wb_step && !wb_last) begin
			rd_en   = 1'b1;
			rd_addr = wb_idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb_start) begin
			wb_idx_q <= '0;
		end else if (cmd.wb_step) begin
			wb_idx_q <= wb_idx_q + IW'(1);
		end
	end

	assign buf_write  = cmd.final_load && (action_q == swc_pkg::ACT_WRITE) && !pass;
	assign buf_append = buf_write && !hit_q;
	assign wr_idx     = hit_q ? hit_idx_q : fill_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (buf_write) begin
			mem_q[wr_idx] <= {phys_q, data_q};
		end
	end

	always_ff @(posedge clk) begin
		if (buf_append) begin
			cam_q[wr_idx] <= phys_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.wb_step && wb_last) begin
			fill_q <= '0;
		end else if (buf_append) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	// saturating wear counter
	assign final_wear = (action_q == swc_pkg::ACT_WRITE) && pass;
	assign wear_bump  = cmd.wb_step || (cmd.final_load && final_wear);
	assign wear_inc   = (wear_q == '1) ? wear_q : wear_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wear_q <= '0;
		end else if (wear_bump) begin
			wear_q <= wear_inc;
		end
	end

	// closing word of an access
	always_comb begin
		fin_kind = swc_pkg::KIND_DONE;
		fin_back = '0;
		fin_data = '0;
		case (action_q)
			swc_pkg::ACT_READ: begin
				if (pass) begin
					fin_kind = swc_pkg::KIND_READ_REQ;
					fin_back = virt_back;
				end else if (hit_q) begin
					fin_kind = swc_pkg::KIND_BUF_DATA;
					fin_back = phys_back;
					fin_data = PB'(rd_q[DW-1:0]);
				end else begin
					fin_kind = swc_pkg::KIND_READ_REQ;
					fin_back = phys_back;
				end
			end
			swc_pkg::ACT_WRITE: begin
				if (pass) begin
					fin_kind = swc_pkg::KIND_WRITE;
					fin_back = virt_back;
					fin_data = PB'(data_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb_step || cmd.final_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb_step) begin
			kind_q     <= swc_pkg::KIND_WRITE;
			back_q     <= BB'(rd_q[MW-1:DW]) + chunk_base;
			dword_q    <= PB'(rd_q[DW-1:0]);
			last_q     <= 1'b0;
			wear_out_q <= wear_inc;
		end else if (cmd.final_load) begin
			kind_q     <= fin_kind;
			back_q     <= fin_back;
			dword_q    <= fin_data;
			last_q     <= 1'b1;
			wear_out_q <= final_wear ? wear_inc : wear_q;
		end
	end

	assign sts.red_skip = (RED_STEPS == 0);
	assign sts.red_done = (red_cnt_q == '0);
	assign sts.need_wb  = ((action_q == swc_pkg::ACT_FLUSH) && (fill_q != '0))
		|| ((action_q == swc_pkg::ACT_WRITE) && !pass && !hit_q
		&& (fill_q == FW'(BUFFER_ENTRIES)));
	assign sts.wb_last  = wb_last;
	assign sts.out_free = out_free;

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign backing_address = back_q;
	assign data_word       = dword_q;
	assign last            = last_q;
	assign wear_count      = wear_out_q;

endmodule

[rtl/shifted_address_write_cache.sv]
// ----------------------------------------------------------------------------
// shifted_address_write_cache
// Wear-levelled segment front end with address rotation and a small fully
// associative write buffer in front of backing store.
// ----------------------------------------------------------------------------
// Each access is taken one at a time and answered by one or more words on the
// result channel, the final one marked by last. An access that causes no
// write-back passes from acceptance to the loading of its result through
// rotation of the address, tag compare, decision and result. When the
// segment is smaller than 1024 words, both the address and the rotation are
// first brought into range by a restoring reduction with one step per
// power-of-two multiple of the segment size below 1024. A flush, or a write
// miss into a full buffer, first writes back each dirty entry, each one
// leaving as a backing write word read from the buffer memory. A result
// waiting on out_ready holds the sequencer. After reset the buffer is empty
// and the block is ready at once. The user must write configuration only
// while no access is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module shifted_address_write_cache #(
	parameter int SEGMENT_WORDS  = swc_pkg::SEGMENT_WORDS_DEF,
	parameter int BUFFER_ENTRIES = swc_pkg::BUFFER_ENTRIES_DEF,
	parameter int DATA_BITS      = swc_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [swc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [swc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic [swc_pkg::ADDR_BITS-1:0]      logical_address,
	input  logic [swc_pkg::DATA_PORT_BITS-1:0] write_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         kind,
	output logic [swc_pkg::BACK_BITS-1:0]      backing_address,
	output logic [swc_pkg::DATA_PORT_BITS-1:0] data_word,
	output logic                               last,
	output logic [31:0]                        wear_count
);

	swc_pkg::cmd_t cmd;
	swc_pkg::sts_t sts;

	swc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	swc_datapath #(
		.SEGMENT_WORDS  (SEGMENT_WORDS),
		.BUFFER_ENTRIES (BUFFER_ENTRIES),
		.DATA_BITS      (DATA_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (action),
		.logical_address (logical_address),
		.write_data      (write_data),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.kind            (kind),
		.backing_address (backing_address),
		.data_word       (data_word),
		.last            (last),
		.wear_count      (wear_count)
	);

endmodule
